FILE: rtl/tgv_pkg.sv
// ----------------------------------------------------------------------------
// tgv_pkg
// Shared widths, register codes and payload types of the terrain grid vertex
// generator.
// ----------------------------------------------------------------------------
package tgv_pkg;

  // Grid and divider geometry
  localparam int MAX_ROW_SIZE = 1024;
  localparam int SLOT_COUNT   = 8;
  localparam int IDX_W        = 20;
  localparam int COL_W        = $clog2(MAX_ROW_SIZE);
  localparam int DIV_W        = COL_W + 1;
  localparam int DIV_STAGES   = 4;
  localparam int DIV_STEPS    = IDX_W / DIV_STAGES;

  // Arithmetic widths
  localparam int STEP_W     = 32;
  localparam int HEIGHT_W   = 32;
  localparam int COEF_W     = 20;
  localparam int TRANS_W    = 21;
  localparam int POS_W      = 32;
  localparam int LANES      = 3;
  localparam int AXIS_W     = LANES * COEF_W;
  localparam int TRANSL_W   = LANES * TRANS_W;
  localparam int PROD_FRAC  = 33;
  localparam int TRANS_FRAC = 8;
  localparam int POS_FRAC   = 16;
  localparam int SLOT_W     = 3;
  localparam int BYTE_W     = 8;
  localparam int ROW_SIZE_W = 11;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ROW_SIZE    = 3'd0,
    REG_GRID_STEP   = 3'd1,
    REG_AXIS_X      = 3'd2,
    REG_AXIS_Y      = 3'd3,
    REG_AXIS_Z      = 3'd4,
    REG_TRANSLATION = 3'd5,
    REG_SLOT_REMAP  = 3'd6
  } cfg_reg_e;

  // Partial division: remaining dividend, quotient so far, running remainder
  typedef struct packed {
    logic [IDX_W-1:0] dvd;
    logic [IDX_W-1:0] quo;
    logic [COL_W-1:0] rem;
  } div_t;

  // Fields that ride along with the vertex
  typedef struct packed {
    logic signed [HEIGHT_W-1:0] height;
    logic [23:0]                blend;
    logic [31:0]                color;
    logic [63:0]                uv1;
    logic [63:0]                uv2;
    logic [63:0]                uv3;
    logic [23:0]                tex;
    logic                       last;
  } pass_t;

  // Transform settings
  typedef struct packed {
    logic [STEP_W-1:0]   step;
    logic [AXIS_W-1:0]   ax;
    logic [AXIS_W-1:0]   ay;
    logic [AXIS_W-1:0]   az;
    logic [TRANSL_W-1:0] trans;
  } xform_cfg_t;

endpackage

FILE: rtl/tgv_div_stage.sv
// ----------------------------------------------------------------------------
// tgv_div_stage
// One registered stage of the index divider: several restoring steps that
// split the vertex index into row and column.
// ----------------------------------------------------------------------------
module tgv_div_stage
  import tgv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  div_t             div_i,
  input  pass_t            pass_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             valid_o,
  input  logic             ready_i,
  output div_t             div_o,
  output pass_t            pass_o
);

  div_t             div_d;
  div_t             div_q;
  pass_t            pass_q;
  logic             valid_q;
  logic [DIV_W-1:0] part;

  // Shift in one dividend bit per step, subtract where it fits
  always_comb begin
    div_d = div_i;
    part  = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      part      = {div_d.rem, div_d.dvd[IDX_W-1]};
      div_d.dvd = {div_d.dvd[IDX_W-2:0], 1'b0};
      if (part >= divisor_i) begin
        div_d.rem = COL_W'(part - divisor_i);
        div_d.quo = {div_d.quo[IDX_W-2:0], 1'b1};
      end else begin
        div_d.rem = part[COL_W-1:0];
        div_d.quo = {div_d.quo[IDX_W-2:0], 1'b0};
      end
    end
  end

  // Advance when empty or when the next stage takes the transfer
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      div_q  <= div_d;
      pass_q <= pass_i;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;
  assign pass_o  = pass_q;

endmodule

FILE: rtl/tgv_transform.sv
// ----------------------------------------------------------------------------
// tgv_transform
// Grid point to world position: scale by the step, apply the affine
// transform, round and saturate to signed Q16.16. Four register stages.
// ----------------------------------------------------------------------------
module tgv_transform
  import tgv_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  xform_cfg_t              cfg_i,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic [IDX_W-1:0]        row_i,
  input  logic [COL_W-1:0]        col_i,
  input  pass_t                   pass_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic signed [POS_W-1:0] pos_x_o,
  output logic signed [POS_W-1:0] pos_y_o,
  output logic signed [POS_W-1:0] pos_z_o,
  output pass_t                   pass_o
);

  localparam int COLP_W = COL_W + STEP_W;
  localparam int ROWP_W = IDX_W + STEP_W;
  localparam int PX_W   = COLP_W + 1 + COEF_W;
  localparam int PH_W   = HEIGHT_W + COEF_W;
  localparam int PZ_W   = ROWP_W + 1 + COEF_W + 1;
  localparam int SUM_W  = PZ_W + 2;
  localparam int SHIFT  = PROD_FRAC - POS_FRAC;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (SHIFT - 1);
  localparam logic signed [SUM_W-1:0] POS_MAX =
    {{(SUM_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] POS_MIN =
    {{(SUM_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};

  logic [3:0] valid_q;
  logic [3:0] adv;

  logic [COLP_W-1:0] colp_d, colp_q;
  logic [ROWP_W-1:0] rowp_d, rowp_q;
  pass_t             pass1_q, pass2_q, pass3_q, pass4_q;

  logic signed [COEF_W-1:0]   cx [LANES];
  logic signed [COEF_W-1:0]   cy [LANES];
  logic signed [COEF_W:0]     nz [LANES];
  logic signed [TRANS_W-1:0]  tr [LANES];
  logic signed [PX_W-1:0]     px_d [LANES];
  logic signed [PX_W-1:0]     px_q [LANES];
  logic signed [PH_W-1:0]     ph_d [LANES];
  logic signed [PH_W-1:0]     ph_q [LANES];
  logic signed [PZ_W-1:0]     pz_d [LANES];
  logic signed [PZ_W-1:0]     pz_q [LANES];
  logic signed [SUM_W-1:0]    sum_d [LANES];
  logic signed [SUM_W-1:0]    sum_q [LANES];
  logic signed [SUM_W-1:0]    shr [LANES];
  logic signed [POS_W-1:0]    pos_d [LANES];
  logic signed [POS_W-1:0]    pos_q [LANES];

  // Stage enables: a stage moves when empty or when its successor moves
  assign adv[3]  = !valid_q[3] || ready_i;
  assign adv[2]  = !valid_q[2] || adv[3];
  assign adv[1]  = !valid_q[1] || adv[2];
  assign adv[0]  = !valid_q[0] || adv[1];
  assign ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) valid_q[0] <= valid_i;
      if (adv[1]) valid_q[1] <= valid_q[0];
      if (adv[2]) valid_q[2] <= valid_q[1];
      if (adv[3]) valid_q[3] <= valid_q[2];
    end
  end

  // Unpack coefficients; the z axis is negated up front
  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      cx[c] = cfg_i.ax[c*COEF_W +: COEF_W];
      cy[c] = cfg_i.ay[c*COEF_W +: COEF_W];
      nz[c] = -{cfg_i.az[c*COEF_W+COEF_W-1], cfg_i.az[c*COEF_W +: COEF_W]};
      tr[c] = cfg_i.trans[c*TRANS_W +: TRANS_W];
    end
  end

  // Stage 1: grid coordinates times the step
  assign colp_d = COLP_W'(col_i) * COLP_W'(cfg_i.step);
  assign rowp_d = ROWP_W'(row_i) * ROWP_W'(cfg_i.step);

  // Stage 2: products with the transform
  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      px_d[c] = $signed({1'b0, colp_q}) * cx[c];
      ph_d[c] = pass1_q.height * cy[c];
      pz_d[c] = $signed({1'b0, rowp_q}) * nz[c];
    end
  end

  // Stage 3: sum with translation and the rounding half
  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      sum_d[c] = SUM_W'(px_q[c]) + SUM_W'(ph_q[c]) + SUM_W'(pz_q[c])
               + (SUM_W'(tr[c]) <<< (PROD_FRAC - TRANS_FRAC)) + ROUND_HALF;
    end
  end

  // Stage 4: drop fraction bits and clamp
  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      shr[c] = sum_q[c] >>> SHIFT;
      if (shr[c] > POS_MAX) begin
        pos_d[c] = POS_MAX[POS_W-1:0];
      end else if (shr[c] < POS_MIN) begin
        pos_d[c] = POS_MIN[POS_W-1:0];
      end else begin
        pos_d[c] = shr[c][POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && valid_i) begin
      colp_q  <= colp_d;
      rowp_q  <= rowp_d;
      pass1_q <= pass_i;
    end
    if (adv[1] && valid_q[0]) begin
      px_q    <= px_d;
      ph_q    <= ph_d;
      pz_q    <= pz_d;
      pass2_q <= pass1_q;
    end
    if (adv[2] && valid_q[1]) begin
      sum_q   <= sum_d;
      pass3_q <= pass2_q;
    end
    if (adv[3] && valid_q[2]) begin
      pos_q   <= pos_d;
      pass4_q <= pass3_q;
    end
  end

  assign valid_o = valid_q[3];
  assign pos_x_o = pos_q[0];
  assign pos_y_o = pos_q[1];
  assign pos_z_o = pos_q[2];
  assign pass_o  = pass4_q;

endmodule

FILE: rtl/terrain_grid_vertex_generator_top.sv
// ----------------------------------------------------------------------------
// terrain_grid_vertex_generator_top
// Turns heightmap samples into transformed, packed terrain vertices.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one heightmap sample per transfer with its linear vertex
//   index; m_axis returns one vertex per sample, in order, with tlast copied.
//   Settings are written over cfg_we_i / cfg_addr_i / cfg_wdata_i while the
//   stream is idle; writes to unknown indexes are dropped.
//   From input transfer to output transfer, four divider stages (five
//   quotient bits each) split the index into row and column, then come
//   step scaling, transform products, the sum and the round/clamp stage.
//   One vertex per cycle without stalls; every stage has its own valid bit.
//   The divider stages, at five restoring steps each, set the stage count.
//   Reset clears all valid bits and loads the default settings: row size 2,
//   step 1.0, identity transform, no translation, all texture slots unused.
//   When the receiver stalls, full stages hold and empty stages keep
//   accepting, so the pipeline fills up before s_axis_tready drops.
// ----------------------------------------------------------------------------
module terrain_grid_vertex_generator_top
  import tgv_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // fields from bit 0: vertex_index[19:0], height[51:20], blend_weights[75:52],
  // vertex_color[107:76], uv_first[171:108], uv_second[235:172],
  // uv_third[299:236], layer_slots[308:300], zero pad
  input  logic [311:0]          s_axis_tdata,
  input  logic                  s_axis_tlast,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // fields from bit 0: pos_x[31:0], pos_y[63:32], pos_z[95:64],
  // blend_word[119:96], diffuse_out[151:120], uv_first_out[215:152],
  // uv_second_out[279:216], uv_third_out[343:280], texture_indices[367:344]
  output logic [367:0]          m_axis_tdata,
  output logic                  m_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [ROW_SIZE_W-1:0] row_size_q;
  logic [63:0]           slot_remap_q;
  xform_cfg_t            xcfg_q;
  logic [DIV_W-1:0]      divisor;

  logic  dv_valid [DIV_STAGES+1];
  logic  dv_ready [DIV_STAGES+1];
  div_t  dv_data  [DIV_STAGES+1];
  pass_t dv_pass  [DIV_STAGES+1];

  logic [SLOT_W-1:0]        slot [LANES];
  logic [LANES*BYTE_W-1:0]  tex;
  logic signed [POS_W-1:0]  pos_x, pos_y, pos_z;
  pass_t                    out_pass;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_size_q   <= ROW_SIZE_W'(2);
      xcfg_q.step  <= STEP_W'(65536);
      xcfg_q.ax    <= AXIS_W'(64'd131072);
      xcfg_q.ay    <= AXIS_W'(64'd137438953472);
      xcfg_q.az    <= AXIS_W'(64'd144115188075855872);
      xcfg_q.trans <= '0;
      slot_remap_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_ROW_SIZE:    row_size_q   <= cfg_wdata_i[ROW_SIZE_W-1:0];
        REG_GRID_STEP:   xcfg_q.step  <= cfg_wdata_i[STEP_W-1:0];
        REG_AXIS_X:      xcfg_q.ax    <= cfg_wdata_i[AXIS_W-1:0];
        REG_AXIS_Y:      xcfg_q.ay    <= cfg_wdata_i[AXIS_W-1:0];
        REG_AXIS_Z:      xcfg_q.az    <= cfg_wdata_i[AXIS_W-1:0];
        REG_TRANSLATION: xcfg_q.trans <= cfg_wdata_i[TRANSL_W-1:0];
        REG_SLOT_REMAP:  slot_remap_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp the row size into the supported range
  always_comb begin
    if (row_size_q < ROW_SIZE_W'(2)) begin
      divisor = DIV_W'(2);
    end else if (32'(row_size_q) > MAX_ROW_SIZE) begin
      divisor = DIV_W'(MAX_ROW_SIZE);
    end else begin
      divisor = DIV_W'(row_size_q);
    end
  end

  // Remap texture slots; the first slot lands in the bottom byte
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      slot[k] = s_axis_tdata[300 + k*SLOT_W +: SLOT_W];
      if (32'(slot[k]) < SLOT_COUNT) begin
        tex[k*BYTE_W +: BYTE_W] = slot_remap_q[32'(slot[k])*BYTE_W +: BYTE_W];
      end else begin
        tex[k*BYTE_W +: BYTE_W] = '1;
      end
    end
  end

  // Unpack the input transfer
  assign dv_valid[0]        = s_axis_tvalid;
  assign s_axis_tready      = dv_ready[0];
  assign dv_data[0].dvd     = s_axis_tdata[IDX_W-1:0];
  assign dv_data[0].quo     = '0;
  assign dv_data[0].rem     = '0;
  assign dv_pass[0].height  = s_axis_tdata[51:20];
  assign dv_pass[0].blend   = s_axis_tdata[75:52];
  assign dv_pass[0].color   = s_axis_tdata[107:76];
  assign dv_pass[0].uv1     = s_axis_tdata[171:108];
  assign dv_pass[0].uv2     = s_axis_tdata[235:172];
  assign dv_pass[0].uv3     = s_axis_tdata[299:236];
  assign dv_pass[0].tex     = tex;
  assign dv_pass[0].last    = s_axis_tlast;

  // Index divider chain
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    tgv_div_stage u_div (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (dv_valid[g]),
      .ready_o   (dv_ready[g]),
      .div_i     (dv_data[g]),
      .pass_i    (dv_pass[g]),
      .divisor_i (divisor),
      .valid_o   (dv_valid[g+1]),
      .ready_i   (dv_ready[g+1]),
      .div_o     (dv_data[g+1]),
      .pass_o    (dv_pass[g+1])
    );
  end

  tgv_transform u_xform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (xcfg_q),
    .valid_i (dv_valid[DIV_STAGES]),
    .ready_o (dv_ready[DIV_STAGES]),
    .row_i   (dv_data[DIV_STAGES].quo),
    .col_i   (dv_data[DIV_STAGES].rem),
    .pass_i  (dv_pass[DIV_STAGES]),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .pos_x_o (pos_x),
    .pos_y_o (pos_y),
    .pos_z_o (pos_z),
    .pass_o  (out_pass)
  );

  // Pack the output transfer
  assign m_axis_tdata = {out_pass.tex, out_pass.uv3, out_pass.uv2, out_pass.uv1,
                         out_pass.color, out_pass.blend, pos_z, pos_y, pos_x};
  assign m_axis_tlast = out_pass.last;

`ifndef NO_ASSERTIONS
  // Column leaving the divider is a true remainder
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_valid[DIV_STAGES] |-> (DIV_W'(dv_data[DIV_STAGES].rem) < divisor))
    else $error("divider remainder not below row size");

  // A stalled divider output holds its result
  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_valid[DIV_STAGES] && !dv_ready[DIV_STAGES] |=>
      dv_valid[DIV_STAGES] && $stable(dv_data[DIV_STAGES]))
    else $error("divider result changed under stall");

  // Nothing leaves the block straight out of reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

  // The input is always taken while the divider front stage is empty
  a_front_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !dv_valid[1] |-> s_axis_tready)
    else $error("input stalled with empty front stage");
`endif

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for terrain_grid_vertex_generator_top. The testbench drives
// heightmap samples into the slave stream and works out each world vertex
// with its own transform arithmetic. It compares every output transfer
// field by field, in order. Settings are changed between phases while the
// stream is idle. Both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
  import tgv_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_NONE = 3'd7;  // no register here
  localparam int DRAIN_CYCLES = 16;                   // pipeline is 8 deep

  typedef struct {
    logic [19:0]        index;
    logic signed [31:0] height;
    logic [23:0]        blend;
    logic [31:0]        color;
    logic [63:0]        uv1, uv2, uv3;
    logic [8:0]         slots;
    logic               last;
  } sample_t;

  typedef struct {
    logic [31:0] px, py, pz;
    logic [23:0] blend;
    logic [31:0] diffuse;
    logic [63:0] uv1, uv2, uv3;
    logic [23:0] tex;
    logic        last;
  } vertex_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic [311:0]          s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [367:0]          m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // Own copy of the settings
  logic [10:0] row_size_q;
  logic [31:0] step_q;
  logic [59:0] ax_q, ay_q, az_q;
  logic [62:0] trans_q;
  logic [63:0] remap_q;

  vertex_t expected_vertices[$];
  int      fail_count = 0;
  int      sample_count = 0;
  int      checked_count = 0;
  int      phase_count = 0;
  bit      send_gaps = 1'b0;
  bit      recv_stalls = 1'b0;
  int      stall_left = 0;

  terrain_grid_vertex_generator_top dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---- transform arithmetic -------------------------------------------------
  function automatic logic [31:0] world_lane(longint x, longint h, longint z, int lane);
    logic signed [127:0] acc;
    logic signed [127:0] cx, cy, cz, t;
    cx  = $signed(ax_q[lane*COEF_W +: COEF_W]);
    cy  = $signed(ay_q[lane*COEF_W +: COEF_W]);
    cz  = $signed(az_q[lane*COEF_W +: COEF_W]);
    t   = $signed(trans_q[lane*TRANS_W +: TRANS_W]);
    acc = 128'(x) * cx + 128'(h) * cy + 128'(z) * cz + (t <<< 25) + 128'sd65536;
    acc = acc >>> 17;
    if (acc > 128'sd2147483647) return 32'h7FFF_FFFF;
    if (acc < -128'sd2147483648) return 32'h8000_0000;
    return acc[31:0];
  endfunction

  function automatic logic [7:0] remap_slot(logic [2:0] slot);
    if (slot >= SLOT_COUNT) return 8'hFF;
    return remap_q[slot*8 +: 8];
  endfunction

  function automatic vertex_t predict_vertex(sample_t s);
    vertex_t v;
    longint  rs, row, col, x, z;
    rs  = row_size_q;
    if (rs < 2) rs = 2;
    if (rs > MAX_ROW_SIZE) rs = MAX_ROW_SIZE;
    row = longint'(s.index) / rs;
    col = longint'(s.index) % rs;
    x   = col * longint'(step_q);
    z   = -(row * longint'(step_q));
    v.px      = world_lane(x, longint'(s.height), z, 0);
    v.py      = world_lane(x, longint'(s.height), z, 1);
    v.pz      = world_lane(x, longint'(s.height), z, 2);
    v.blend   = s.blend;
    v.diffuse = s.color;
    v.uv1     = s.uv1;
    v.uv2     = s.uv2;
    v.uv3     = s.uv3;
    v.tex     = {remap_slot(s.slots[8:6]), remap_slot(s.slots[5:3]),
                 remap_slot(s.slots[2:0])};
    v.last    = s.last;
    return v;
  endfunction

  // ---- stimulus helpers -----------------------------------------------------
  task automatic send_sample(sample_t s);
    int gap;
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tlast  = s.last;
    s_axis_tdata  = {3'b0, s.slots, s.uv3, s.uv2, s.uv1, s.color, s.blend,
                     s.height, s.index};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_vertices.insert(expected_vertices.size(), predict_vertex(s));
    sample_count++;
  endtask

  // Hold the sender until every vertex is out, then let the pipe settle
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_vertices.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [63:0] val);
    drain();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_ROW_SIZE:    row_size_q = val[10:0];
      REG_GRID_STEP:   step_q     = val[31:0];
      REG_AXIS_X:      ax_q       = val[59:0];
      REG_AXIS_Y:      ay_q       = val[59:0];
      REG_AXIS_Z:      az_q       = val[59:0];
      REG_TRANSLATION: trans_q    = val[62:0];
      REG_SLOT_REMAP:  remap_q    = val;
      default: ;
    endcase
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    int      sel;
    sel = $urandom_range(0, 3);
    // mostly indices inside a plausible grid, sometimes anywhere
    if (sel == 0) s.index = 20'($urandom);
    else s.index = 20'($urandom_range(0, 4 * int'(row_size_q) + 7));
    sel = $urandom_range(0, 3);
    if (sel == 0) s.height = $urandom;
    else if (sel == 1) s.height = $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
    else s.height = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
    s.blend = 24'($urandom);
    s.color = $urandom;
    s.uv1   = rand64();
    s.uv2   = rand64();
    s.uv3   = rand64();
    s.slots = 9'($urandom);
    s.last  = ($urandom_range(0, 7) == 0);
    return s;
  endfunction

  function automatic sample_t plain_sample(logic [19:0] idx, logic signed [31:0] h);
    sample_t s;
    s       = rand_sample();
    s.index = idx;
    s.height = h;
    return s;
  endfunction

  // Small random gain near a unit axis, or fully random
  function automatic logic [59:0] rand_axis(int unit_lane);
    logic [59:0] a;
    if ($urandom_range(0, 3) == 0) return 60'(rand64());
    for (int l = 0; l < 3; l++) begin
      a[l*20 +: 20] = 20'($urandom_range(0, 20'h1FFFF) - 20'h0FFFF);
      if (l == unit_lane)
        a[l*20 +: 20] = 20'(20'h20000 + $urandom_range(0, 20'h0FFFF) - 20'h07FFF);
    end
    return a;
  endfunction

  // ---- output checks --------------------------------------------------------
  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch on vertex %0d, %s: got %h want %h", checked_count, field, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    vertex_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_vertices.size() == 0) begin
        report("unexpected transfer", m_axis_tdata[63:0], '0);
      end else begin
        e = expected_vertices.pop_front();
        if (m_axis_tdata[31:0] !== e.px)
          report("pos_x", 64'(m_axis_tdata[31:0]), 64'(e.px));
        if (m_axis_tdata[63:32] !== e.py)
          report("pos_y", 64'(m_axis_tdata[63:32]), 64'(e.py));
        if (m_axis_tdata[95:64] !== e.pz)
          report("pos_z", 64'(m_axis_tdata[95:64]), 64'(e.pz));
        if (m_axis_tdata[119:96] !== e.blend)
          report("blend_word", 64'(m_axis_tdata[119:96]), 64'(e.blend));
        if (m_axis_tdata[151:120] !== e.diffuse)
          report("diffuse_out", 64'(m_axis_tdata[151:120]), 64'(e.diffuse));
        if (m_axis_tdata[215:152] !== e.uv1) report("uv_first", m_axis_tdata[215:152], e.uv1);
        if (m_axis_tdata[279:216] !== e.uv2) report("uv_second", m_axis_tdata[279:216], e.uv2);
        if (m_axis_tdata[343:280] !== e.uv3) report("uv_third", m_axis_tdata[343:280], e.uv3);
        if (m_axis_tdata[367:344] !== e.tex)
          report("texture_indices", 64'(m_axis_tdata[367:344]), 64'(e.tex));
        if (m_axis_tlast !== e.last) report("tlast", 64'(m_axis_tlast), 64'(e.last));
      end
      checked_count++;
    end
  end

  // Receiver stalls in bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (recv_stalls && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 6);
    end
    m_axis_tready <= (stall_left == 0);
  end

  // ---- tests ----------------------------------------------------------------
  task automatic test_reset_settings();
    row_size_q = 11'd2;
    step_q     = 32'h0001_0000;
    ax_q       = 60'd131072;
    ay_q       = 60'd137438953472;
    az_q       = 60'd144115188075855872;
    trans_q    = '0;
    remap_q    = '1;
    send_sample(plain_sample(20'd0, 32'sd0));
    send_sample(plain_sample(20'd5, 32'sh0003_8000));
    send_sample(plain_sample(20'hFFFFF, 32'sh7FFF_FFFF));
    phase_count++;
  endtask

  task automatic test_directed_extremes();
    sample_t s;
    write_reg(REG_SLOT_REMAP, 64'h0706_0504_0302_0100);
    write_reg(REG_TRANSLATION, {1'b0, 21'h0FFFFF, 21'h100000, 21'h000100});
    write_reg(REG_ROW_SIZE, 64'd0);       // clamps up to two
    send_sample(plain_sample(20'd3, 32'sh8000_0000));
    write_reg(REG_ROW_SIZE, 64'd1);
    send_sample(plain_sample(20'd7, 32'sd1));
    write_reg(REG_ROW_SIZE, 64'd2047);    // clamps down to the maximum
    write_reg(REG_GRID_STEP, 64'hFFFF_FFFF);
    send_sample(plain_sample(20'hFFFFF, 32'sh7FFF_FFFF));
    send_sample(plain_sample(20'd1023, 32'sh8000_0000));
    write_reg(REG_ROW_SIZE, 64'd1024);
    send_sample(plain_sample(20'd1024, 32'sd0));
    write_reg(REG_GRID_STEP, 64'd0);
    write_reg(REG_AXIS_X, {4'h0, 20'h7FFFF, 20'h80000, 20'h7FFFF});
    write_reg(REG_AXIS_Y, {4'h0, 20'h80000, 20'h7FFFF, 20'h80000});
    write_reg(REG_AXIS_Z, {4'h0, 20'h00001, 20'hFFFFF, 20'h00000});
    send_sample(plain_sample(20'hFFFFF, 32'sh7FFF_FFFF));
    send_sample(plain_sample(20'd0, 32'sh8000_0000));
    send_sample(plain_sample(20'd1, -32'sd1));
    // unknown index: settings stay as they are
    write_reg(REG_NONE, 64'h0123_4567_89AB_CDEF);
    write_reg(REG_GRID_STEP, 64'h0000_8000);
    write_reg(REG_TRANSLATION, {1'b0, 21'h100000, 21'h0FFFFF, 21'h100000});
    for (int i = 0; i < 12; i++) begin
      s = rand_sample();
      s.slots = {3'(i), 3'(7 - i), 3'(i + 3)};
      s.blend = (i % 2) ? 24'hFFFFFF : 24'h000000;
      s.color = (i % 2) ? 32'h0 : 32'hFFFF_FFFF;
      s.uv1   = (i % 2) ? 64'h0 : '1;
      s.uv2   = (i % 2) ? '1 : 64'h0;
      s.uv3   = (i % 2) ? 64'h0 : '1;
      s.last  = 1'(i % 2);
      send_sample(s);
    end
    phase_count++;
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_ROW_SIZE,
                (p % 3 == 0) ? 64'(11'($urandom)) : 64'($urandom_range(2, 40)));
      write_reg(REG_GRID_STEP,
                (p == 3) ? 64'($urandom) : 64'($urandom_range(0, 32'h0008_0000)));
      write_reg(REG_AXIS_X, 64'(rand_axis(0)));
      write_reg(REG_AXIS_Y, 64'(rand_axis(1)));
      write_reg(REG_AXIS_Z, 64'(rand_axis(2)));
      write_reg(REG_TRANSLATION, rand64());
      write_reg(REG_SLOT_REMAP, rand64());
      send_gaps   = (p < 7);
      recv_stalls = (p < 7);
      if (p == 7) drain();
      for (int i = 0; i < 200; i++) begin
        if (i == 100 && p == 2) drain();  // hold off until all vertices are out
        send_sample(rand_sample());
      end
      phase_count++;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_settings();
    test_directed_extremes();
    test_random_phases();
    drain();
    $display("Sent %0d samples over %0d settings phases, %0d vertices checked,",
             sample_count, phase_count, checked_count);
    $display("covering row-size clamping, step and gain extremes and saturation.");
    if (fail_count == 0 && expected_vertices.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout waiting for the stream to finish");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/tgv_pkg.sv
rtl/tgv_div_stage.sv
rtl/tgv_transform.sv
rtl/terrain_grid_vertex_generator_top.sv
verif/tb_top.sv
